FILE: rtl/cpr_pkg.sv
package cpr_pkg;

  localparam int FRAMES    = 64;
  localparam int PAGE_BITS = 20;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PAGE_BITS-1:0] page_t;

  // Access to the page table for one cycle
  typedef struct packed {
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    page_t wr_data;
    page_t key;
  } tbl_req_t;

endpackage

FILE: rtl/cpr_page_table.sv
module cpr_page_table
  import cpr_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output logic     match
);

  page_t mem [FRAMES];
  page_t rd_data;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

  // Shared comparator: entry read last cycle against the looked-up page
  assign match = (rd_data == req.key);

endmodule

FILE: rtl/clock_page_replacement.sv
// Channel  Signals                                   Direction
// -------  ----------------------------------------  ---------
// in       in_valid, in_ready, page_number, last_ref  into block
// out      out_valid, out_ready, hit, frame_index,    out of block
//          fault_count
//
// One reference at a time. The lookup reads the page table one frame per
// cycle from frame 0 and stops at the first valid frame that matches.
// A miss then sweeps the hand one frame per cycle, clearing set bits, to
// the first frame whose reference bit is clear. Either result moves into
// the output register; in_ready rises with out_valid, even while that
// result waits for out_ready. A finished item whose output slot is still
// occupied holds until the slot frees. Reset (rst, synchronous) empties
// the table at once; last_ref does the same when its result is loaded.
module clock_page_replacement
  import cpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] page_number,
  input  logic        last_ref,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [5:0]  frame_index,
  output logic [31:0] fault_count
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state;
  page_t             page;
  logic              last;
  idx_t              scan_idx;
  idx_t              cmp_idx;
  logic              cmp_live;
  idx_t              hand;
  logic [31:0]       faults;
  logic [FRAMES-1:0] valid;
  logic [FRAMES-1:0] refb;
  logic              work_hit;
  idx_t              work_frame;
  logic              match;
  tbl_req_t          req;
  idx_t              hand_next;
  idx_t              scan_next;

  assign in_ready  = (state == S_IDLE);
  assign hand_next = (hand == LAST_IDX) ? '0 : hand + 1'b1;
  assign scan_next = (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;

  always_comb begin
    req.rd_addr = scan_idx;
    req.wr_en   = (state == S_SWEEP) && !refb[hand];
    req.wr_addr = hand;
    req.wr_data = page;
    req.key     = page;
  end

  cpr_page_table u_table (
    .clk   (clk),
    .req   (req),
    .match (match)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      page <= PAGE_BITS'(page_number);
      last <= last_ref;
    end
    if (state == S_SCAN && cmp_live && valid[cmp_idx] && match) begin
      work_hit   <= 1'b1;
      work_frame <= cmp_idx;
    end
    if (state == S_SWEEP && !refb[hand]) begin
      work_hit   <= 1'b0;
      work_frame <= hand;
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      hit         <= work_hit;
      frame_index <= 6'(work_frame);
      fault_count <= faults;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_idx  <= '0;
      cmp_idx   <= '0;
      cmp_live  <= 1'b0;
      hand      <= '0;
      faults    <= '0;
      valid     <= '0;
      refb      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            scan_idx <= '0;
            cmp_live <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cmp_live && valid[cmp_idx] && match) begin
            refb[cmp_idx] <= 1'b1;
            state         <= S_DONE;
          end else if (cmp_live && cmp_idx == LAST_IDX) begin
            if (faults != '1) begin
              faults <= faults + 32'd1;
            end
            state <= S_SWEEP;
          end else begin
            cmp_idx  <= scan_idx;
            cmp_live <= 1'b1;
            scan_idx <= scan_next;
          end
        end
        S_SWEEP: begin
          if (!refb[hand]) begin
            valid[hand] <= 1'b1;
            refb[hand]  <= 1'b1;
            state       <= S_DONE;
          end else begin
            // second chance: clear and advance
            refb[hand] <= 1'b0;
            hand       <= hand_next;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
            if (last) begin
              valid  <= '0;
              refb   <= '0;
              hand   <= '0;
              faults <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import cpr_pkg::*;

  typedef struct {
    logic        hit;
    logic [5:0]  frame;
    logic [31:0] faults;
  } ref_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [19:0] page_number = '0;
  logic        last_ref = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [5:0]  frame_index;
  logic [31:0] fault_count;

  // Shadow copy of the frame table
  page_t       shadow_page [FRAMES];
  logic        shadow_valid [FRAMES];
  logic        shadow_ref [FRAMES];
  idx_t        shadow_hand;
  logic [31:0] shadow_faults;

  ref_result_t ref_results_q[$];
  int          error_cnt = 0;
  bit          idle_on = 1'b1;

  clock_page_replacement i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .page_number (page_number),
    .last_ref    (last_ref),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .frame_index (frame_index),
    .fault_count (fault_count)
  );

  always #2 clk = ~clk;

  function automatic void clear_shadow();
    for (int i = 0; i < FRAMES; i++) begin
      shadow_page[i]  = '0;
      shadow_valid[i] = 1'b0;
      shadow_ref[i]   = 1'b0;
    end
    shadow_hand   = '0;
    shadow_faults = '0;
  endfunction

  function automatic ref_result_t resolve_ref(page_t pg, logic lst);
    ref_result_t res;
    int          where;
    where = -1;
    for (int i = 0; i < FRAMES; i++) begin
      if (where < 0 && shadow_valid[i] && shadow_page[i] == pg) where = i;
    end
    if (where >= 0) begin
      res.hit = 1'b1;
      res.frame = 6'(where);
      shadow_ref[where] = 1'b1;
    end else begin
      res.hit = 1'b0;
      if (shadow_faults != '1) shadow_faults++;
      // give each set bit a second chance
      for (int steps = 0; steps <= FRAMES && shadow_ref[shadow_hand]; steps++) begin
        shadow_ref[shadow_hand] = 1'b0;
        shadow_hand = (shadow_hand == LAST_IDX) ? '0 : shadow_hand + 1'b1;
      end
      shadow_page[shadow_hand]  = pg;
      shadow_valid[shadow_hand] = 1'b1;
      shadow_ref[shadow_hand]   = 1'b1;
      res.frame = 6'(shadow_hand);
    end
    res.faults = shadow_faults;
    if (lst) clear_shadow();
    return res;
  endfunction

  task automatic send_ref(input page_t pg, input logic lst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    page_number <= pg;
    last_ref    <= lst;
    do @(posedge clk); while (!in_ready);
    ref_results_q = {ref_results_q, resolve_ref(pg, lst)};
  endtask

  // Receiver: stall in bursts, with long stretches of steady ready
  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    ref_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (ref_results_q.size() == 0) begin
        $error("result transfer with nothing expected");
        error_cnt++;
      end else begin
        want = ref_results_q.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          error_cnt++;
        end
        if (frame_index !== want.frame) begin
          $error("frame_index: expected %0d, got %0d", want.frame, frame_index);
          error_cnt++;
        end
        if (fault_count !== want.faults) begin
          $error("fault_count: expected %0d, got %0d", want.faults, fault_count);
          error_cnt++;
        end
      end
    end
  end

  task automatic test_edge_pages();
    send_ref(20'h00000, 1'b0);
    send_ref(20'hFFFFF, 1'b0);
    send_ref(20'h00000, 1'b0);
    send_ref(20'hFFFFF, 1'b0);
    send_ref(20'hAAAAA, 1'b0);
    send_ref(20'h55555, 1'b0);
    send_ref(20'hAAAAA, 1'b0);
    send_ref(20'h55555, 1'b1);
    // table is empty again: these must miss
    send_ref(20'h00000, 1'b0);
    send_ref(20'hFFFFF, 1'b1);
  endtask

  task automatic test_run_end();
    send_ref(20'h12345, 1'b1);
    send_ref(20'h12345, 1'b1);
    send_ref(20'h00001, 1'b0);
    send_ref(20'h80000, 1'b0);
    send_ref(20'h00001, 1'b1);
  endtask

  // Fill every frame, reference them all, then miss so the hand laps the table
  task automatic test_full_sweep();
    page_t base;
    int    rot;
    base = page_t'($urandom);
    rot  = $urandom_range(0, FRAMES - 1);
    for (int i = 0; i < FRAMES; i++) send_ref(base + page_t'(i), 1'b0);
    for (int i = 0; i < FRAMES; i++) send_ref(base + page_t'((i + rot) % FRAMES), 1'b0);
    send_ref(base + page_t'(FRAMES), 1'b0);
    send_ref(base + page_t'(rot), 1'b0);
    send_ref(base + page_t'(FRAMES + 1), 1'b1);
  endtask

  // Runs over a working set that may exceed the table, with some noise pages
  task automatic test_random_runs(input int n_items);
    page_t pool [128];
    int    pool_n;
    int    run_len;
    int    sent;
    page_t pg;
    sent = 0;
    while (sent < n_items) begin
      pool_n  = $urandom_range(8, 128);
      run_len = $urandom_range(1, 160);
      for (int i = 0; i < pool_n; i++) pool[i] = page_t'($urandom);
      for (int i = 0; i < run_len && sent < n_items; i++) begin
        if ($urandom_range(0, 99) < 85) pg = pool[$urandom_range(0, pool_n - 1)];
        else pg = page_t'($urandom);
        sent++;
        send_ref(pg, (i == run_len - 1 || sent == n_items) ? 1'b1 : 1'b0);
      end
    end
  endtask

  initial begin
    clear_shadow();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_edge_pages();
    test_run_end();
    test_full_sweep();
    test_random_runs(330);
    idle_on = 1'b0;
    test_random_runs(125);
    in_valid <= 1'b0;
    while (ref_results_q.size() != 0) @(posedge clk);
    repeat (2 * FRAMES + 40) @(posedge clk);
    if (error_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
